// File: rtl/core/fdcm_pkg.sv
// ----------------------------------------------------------------------------
// fdcm_pkg
// Shared widths, register indexes and the controller/datapath interface types
// of the frequency and duty capture meter.
// ----------------------------------------------------------------------------
package fdcm_pkg;

    localparam int FREQ_W    = 27;
    localparam int DUTY_W    = 7;
    localparam int WAIT_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUTY_W-1:0]    DUTY_FULL       = 7'd100;
    localparam logic [WAIT_W-1:0]    WAIT_MAX        = 20'hFFFFF;
    localparam logic [FREQ_W-1:0]    CLOCK_FREQ_RST  = 27'd16000000;
    localparam logic [WAIT_W-1:0]    TIMEOUT_RST     = 20'd100000;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;        // input beat taken this cycle
        logic cap_first;     // capture count at first rising edge
        logic cap_fall;      // capture count at falling edge
        logic cap_rise2;     // latch period and scaled high time
        logic clr_wait;
        logic inc_wait;
        logic div_start;
        logic div_sel_duty;  // divider operands: 0 frequency, 1 duty
        logic latch_freq;
        logic load_timeout;
        logic load_meas;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic rise;
        logic fall;
        logic period_zero;
        logic wait_expire;
        logic out_free;
        logic div_busy;
    } t_dp_sts;

endpackage

// File: rtl/core/fdcm_div.sv
// ----------------------------------------------------------------------------
// fdcm_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient holds
// after the last step until the next start.
// ----------------------------------------------------------------------------
module fdcm_div #(
    parameter int DW = 27,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quo;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/fdcm_dp.sv
// ----------------------------------------------------------------------------
// fdcm_dp
// Datapath: tick counter, edge detect, capture registers, wait counter,
// configuration registers, divider and the output register.
// ----------------------------------------------------------------------------
module fdcm_dp
    import fdcm_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_pin_level,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FREQ_W-1:0]    o_freq_hz,
    output logic [DUTY_W-1:0]    o_duty_percent,
    output logic                 o_timed_out
);

    localparam int HW = CB + DUTY_W;
    localparam int DW = (HW > FREQ_W) ? HW : FREQ_W;

    logic [FREQ_W-1:0] r_clock_freq;
    logic [WAIT_W-1:0] r_timeout;
    logic [CB-1:0]     r_tick;
    logic              r_last;
    logic [CB-1:0]     r_first;
    logic [CB-1:0]     r_fall;
    logic [WAIT_W-1:0] r_wait;
    logic [CB-1:0]     r_period;
    logic [HW-1:0]     r_high100;
    logic [FREQ_W-1:0] r_freq;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_out_freq;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_to;

    logic [CB-1:0]     period;
    logic [CB-1:0]     high;
    logic [WAIT_W-1:0] wait_inc;
    logic [DW-1:0]     div_dividend;
    logic [CB-1:0]     div_divisor;
    logic              div_busy;
    logic [DW-1:0]     div_quo;
    logic [DUTY_W-1:0] duty_sat;

    assign period   = r_tick - r_first;
    assign high     = r_fall - r_first;
    assign wait_inc = (r_wait < WAIT_MAX) ? r_wait + WAIT_W'(1) : r_wait;

    assign div_dividend = i_cmd.div_sel_duty ? DW'(r_high100) : DW'(r_clock_freq);
    assign div_divisor  = i_cmd.div_sel_duty ? r_period : period;
    assign duty_sat     = (div_quo > DW'(DUTY_FULL)) ? DUTY_FULL : div_quo[DUTY_W-1:0];

    fdcm_div #(
        .DW (DW),
        .VW (CB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_comb begin
        o_sts.rise        = !r_last && i_pin_level;
        o_sts.fall        = r_last && !i_pin_level;
        o_sts.period_zero = (period == '0);
        o_sts.wait_expire = (wait_inc >= r_timeout);
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.div_busy    = div_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_freq <= CLOCK_FREQ_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CLOCK_FREQ) begin
                r_clock_freq <= i_cfg_data;
            end else if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[WAIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_last  <= 1'b0;
            r_first <= '0;
            r_fall  <= '0;
            r_wait  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_tick <= r_tick + CB'(1);
                r_last <= i_pin_level;
            end
            if (i_cmd.cap_first) begin
                r_first <= r_tick;
            end
            if (i_cmd.cap_fall) begin
                r_fall <= r_tick;
            end
            if (i_cmd.clr_wait) begin
                r_wait <= '0;
            end else if (i_cmd.inc_wait) begin
                r_wait <= wait_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_rise2) begin
            r_period  <= period;
            r_high100 <= HW'(high) * HW'(DUTY_FULL);
        end
        if (i_cmd.latch_freq) begin
            r_freq <= div_quo[FREQ_W-1:0];
        end
    end

    // output register: hold the beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_timeout || i_cmd.load_meas) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_timeout) begin
            r_out_freq <= '0;
            r_out_duty <= '0;
            r_out_to   <= 1'b1;
        end else if (i_cmd.load_meas) begin
            r_out_freq <= r_freq;
            r_out_duty <= duty_sat;
            r_out_to   <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_freq_hz      = r_out_freq;
    assign o_duty_percent = r_out_duty;
    assign o_timed_out    = r_out_to;

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_timeout && i_cmd.load_meas))
        else $error("timeout and measurement loaded together");

    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wait |=> (r_wait == '0))
        else $error("wait counter not cleared");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= DUTY_FULL))
        else $error("duty above full scale");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_to) |-> (r_out_freq == '0 && r_out_duty == '0))
        else $error("timeout beat carries nonzero data");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> div_busy)
        else $error("divider did not start");

endmodule

// File: rtl/core/fdcm_ctrl.sv
// ----------------------------------------------------------------------------
// fdcm_ctrl
// Controller: edge wait sequence, timeout decision and division sequencing.
// ----------------------------------------------------------------------------
module fdcm_ctrl
    import fdcm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_RISE1,
        S_FALL,
        S_RISE2,
        S_DIV_FREQ,
        S_DIV_DUTY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   wait_phase;
    logic   accept;
    logic   got;

    assign wait_phase = r_state inside {S_RISE1, S_FALL, S_RISE2};
    assign o_in_ready = wait_phase && i_sts.out_free;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        case (r_state)
            S_RISE1: got = i_sts.rise;
            S_FALL:  got = i_sts.fall;
            S_RISE2: got = i_sts.rise;
            default: got = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        n_state      = r_state;
        case (r_state)
            S_RISE1, S_FALL, S_RISE2: begin
                if (accept) begin
                    if (got) begin
                        o_cmd.clr_wait = 1'b1;
                        if (r_state == S_RISE1) begin
                            o_cmd.cap_first = 1'b1;
                            n_state         = S_FALL;
                        end else if (r_state == S_FALL) begin
                            o_cmd.cap_fall = 1'b1;
                            n_state        = S_RISE2;
                        end else if (i_sts.period_zero) begin
                            // drop the measurement, start over
                            n_state = S_RISE1;
                        end else begin
                            o_cmd.cap_rise2 = 1'b1;
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV_FREQ;
                        end
                    end else if (i_sts.wait_expire) begin
                        o_cmd.clr_wait     = 1'b1;
                        o_cmd.load_timeout = 1'b1;
                        n_state            = S_RISE1;
                    end else begin
                        o_cmd.inc_wait = 1'b1;
                    end
                end
            end
            S_DIV_FREQ: begin
                if (!i_sts.div_busy) begin
                    o_cmd.latch_freq   = 1'b1;
                    o_cmd.div_start    = 1'b1;
                    o_cmd.div_sel_duty = 1'b1;
                    n_state            = S_DIV_DUTY;
                end
            end
            S_DIV_DUTY: begin
                o_cmd.div_sel_duty = 1'b1;
                if (!i_sts.div_busy && i_sts.out_free) begin
                    o_cmd.load_meas = 1'b1;
                    n_state         = S_RISE1;
                end
            end
            default: n_state = S_RISE1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RISE1;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> i_sts.out_free)
        else $error("beat accepted with output full");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_FREQ || r_state == S_DIV_DUTY) |-> !o_in_ready)
        else $error("input taken during division");

    a_rise2_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cap_rise2) |=> (r_state == S_DIV_FREQ))
        else $error("division not entered after closing edge");

endmodule

// File: rtl/core/freq_duty_capture_meter.sv
// ----------------------------------------------------------------------------
// freq_duty_capture_meter
// Input-capture frequency and duty meter built from a controller, a datapath
// and a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Each input beat on i_in_* is one timer tick with the sampled pin level.
// The meter waits for a rising, a falling and a second rising edge,
// capturing a free-running COUNTER_BITS counter at each, then divides the
// configured clock rate by the period and the scaled high time by the period.
// Results leave on o_out_* as one beat: freq_hz, duty_percent, timed_out.
// Config writes (index 0 clock rate, index 1 timeout) use i_cfg_*; the port
// is always ready; the user must write it only while the meter is idle, and
// the block does not enforce it. Throughput: one tick per cycle while
// waiting for edges and the output register is free. After the closing
// edge the input stalls for two divisions, one quotient bit per cycle each.
// The measurement beat is loaded once the duty division ends and the output
// register is free; a timeout beat is valid in the cycle after its tick.
// The output register holds one result; a new tick is taken while it waits
// as long as the receiver takes it in the same cycle or it is empty.
// Reset (synchronous, active low) clears counters and the edge sequence and
// restores the register defaults.
// ----------------------------------------------------------------------------
module freq_duty_capture_meter
    import fdcm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_pin_level,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FREQ_W-1:0]    i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FREQ_W-1:0]    o_freq_hz,
    output logic [DUTY_W-1:0]    o_duty_percent,
    output logic                 o_timed_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    fdcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fdcm_dp #(
        .CB (COUNTER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pin_level    (i_pin_level),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_freq_hz      (o_freq_hz),
        .o_duty_percent (o_duty_percent),
        .o_timed_out    (o_timed_out)
    );

endmodule
